>>> rtl/note_step_sequencer_glide_core_macros.svh
// Assertion helpers for the step sequencer. Both expect clk and rst_n in scope.
`ifndef NOTE_STEP_SEQUENCER_GLIDE_CORE_MACROS_SVH
`define NOTE_STEP_SEQUENCER_GLIDE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define NSSG_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sequencer invariant violated");
// When the trigger holds, the outcome must hold in the next cycle.
`define NSSG_ASSERT_NEXT(lbl, trig, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error("sequencer next-cycle check violated");
`else
`define NSSG_ASSERT_ALWAYS(lbl, cond)
`define NSSG_ASSERT_NEXT(lbl, trig, outcome)
`endif

`endif

>>> rtl/nssg_pkg.sv
package nssg_pkg;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLIDE       = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam int NOTE_W   = 7;
    localparam int SAMPLE_W = 22;
    localparam int GLIDE_W  = 13;

    localparam logic [15:0]         STEP_LENGTH_RESET = 16'd5512;
    localparam logic [15:0]         GATE_LENGTH_RESET = 16'd4500;
    localparam logic [GLIDE_W-1:0]  GLIDE_RESET       = 13'd0;
    localparam logic [GLIDE_W-1:0]  GLIDE_FULL        = 13'd4096;
    localparam logic [SAMPLE_W-1:0] PREV_RESET        = 22'd3270;

    typedef struct packed {
        logic              op;
        logic [7:0]        entry_index;
        logic [NOTE_W-1:0] entry_note;
    } in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic [7:0]          current_step;
    } out_t;

    // Pitch words of the octave that starts at note 60.
    function automatic logic [16:0] pitch_word(input logic [3:0] semitone);
        logic [16:0] w;
        case (semitone)
            4'd0:    w = 17'd52325;
            4'd1:    w = 17'd55436;
            4'd2:    w = 17'd58733;
            4'd3:    w = 17'd62225;
            4'd4:    w = 17'd65925;
            4'd5:    w = 17'd69845;
            4'd6:    w = 17'd73999;
            4'd7:    w = 17'd78399;
            4'd8:    w = 17'd83061;
            4'd9:    w = 17'd88000;
            4'd10:   w = 17'd93233;
            4'd11:   w = 17'd98776;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // Note number to pitch word. The octave comes from a multiply by 43/512,
    // which equals the floor of note/12 for every 7-bit note.
    function automatic logic [SAMPLE_W-1:0] note_pitch(input logic [NOTE_W-1:0] note);
        logic [12:0]         prod;
        logic [3:0]          oct;
        logic [6:0]          oct_x12;
        logic [3:0]          semi;
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] res;
        prod    = 13'(note) * 13'd43;
        oct     = prod[12:9];
        oct_x12 = 7'(oct) * 7'd12;
        semi    = 4'(note - oct_x12);
        base    = SAMPLE_W'(pitch_word(semi));
        if (note == '0)
            res = '0;
        else if (note < 7'd60)
            res = base >> (4'd5 - oct);
        else
            res = base << (oct - 4'd5);
        return res;
    endfunction

endpackage

>>> rtl/nssg_ram.sv
module nssg_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/note_step_sequencer_glide_core.sv
// Step sequencer with glide, one audio sample per tick beat.
// The input channel (in_valid/in_ready/in_data) carries two kinds of beat: a tick,
// which produces exactly one result beat, and a pattern write, which loads one
// step of the pattern memory and produces nothing. Result beats leave on
// out_valid/out_ready/out_data in the order the ticks were accepted.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; it sets step length, gate length and glide, and is meant to be used only
// while no tick is in flight. Unknown indexes are ignored.
// A tick taken passes through stage one, stage two and the output register, which
// offers it as a result beat. One beat is accepted every cycle while the
// receiver keeps up. The rate is set by the glide recurrence: the mix of the
// previous output with the new pitch word is one registered stage of two small
// multiplies and an add, which closes on itself every cycle.
// After reset the pattern memory is swept to zero, one entry a cycle, so in_ready
// stays low until the sweep ends; configuration writes are taken during the sweep.
// When the receiver stalls, the whole pipeline holds and in_ready drops, so no
// beat is lost; in_ready returns in the cycle the output beat is taken.
`include "note_step_sequencer_glide_core_macros.svh"

module note_step_sequencer_glide_core #(
    parameter int STEPS = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  nssg_pkg::in_t                        in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output nssg_pkg::out_t                       out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nssg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [nssg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = $clog2(STEPS);
    localparam logic [AW-1:0] LAST_STEP = AW'(STEPS - 1);

    // Configuration registers.
    logic [15:0]                  step_length_reg;
    logic [15:0]                  gate_length_reg;
    logic [nssg_pkg::GLIDE_W-1:0] glide_reg;

    // Sequencer position.
    logic [AW-1:0] step_reg;
    logic [15:0]   count_reg;
    logic [AW-1:0] step_next;
    logic [15:0]   count_next;
    logic [15:0]   count_inc;

    // Reset sweep of the pattern memory.
    logic          clear_active_reg;
    logic [AW-1:0] clear_addr_reg;

    // Pipeline: stage one holds the memory read, stage two the pitch word.
    logic                            advance;
    logic                            tick_accept;
    logic                            write_accept;
    logic                            s1_valid_reg;
    logic                            s1_gate_off_reg;
    logic [AW-1:0]                   s1_step_reg;
    logic                            s2_valid_reg;
    logic                            s2_gate_off_reg;
    logic [AW-1:0]                   s2_step_reg;
    logic [nssg_pkg::SAMPLE_W-1:0]   s2_target_reg;
    logic [nssg_pkg::SAMPLE_W-1:0]   prev_reg;
    logic [nssg_pkg::SAMPLE_W-1:0]   prev_next;
    logic                            out_valid_reg;
    nssg_pkg::out_t                  out_data_reg;

    logic [nssg_pkg::NOTE_W-1:0]     ram_rdata;
    logic                            ram_we;
    logic [AW-1:0]                   ram_waddr;
    logic [nssg_pkg::NOTE_W-1:0]     ram_wdata;
    logic                            index_in_range;

    logic [nssg_pkg::GLIDE_W-1:0]    glide_sat;
    logic [nssg_pkg::GLIDE_W-1:0]    glide_rest;
    logic [35:0]                     mix_full;

    // The whole pipeline moves whenever the output register is free or being taken.
    assign advance      = !out_valid_reg || out_ready;
    assign in_ready     = advance && !clear_active_reg;
    assign tick_accept  = in_valid && in_ready && (in_data.op == nssg_pkg::OP_TICK);
    assign write_accept = in_valid && in_ready && (in_data.op == nssg_pkg::OP_WRITE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;

    // Writes to steps beyond the pattern length are dropped.
    assign index_in_range = 32'(in_data.entry_index) < 32'(STEPS);

    assign ram_we    = clear_active_reg || (write_accept && index_in_range);
    assign ram_waddr = clear_active_reg ? clear_addr_reg : AW'(in_data.entry_index);
    assign ram_wdata = clear_active_reg ? '0 : in_data.entry_note;

    nssg_ram #(
        .WIDTH (nssg_pkg::NOTE_W),
        .DEPTH (STEPS)
    ) u_pattern (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (tick_accept),
        .raddr (step_reg),
        .rdata (ram_rdata)
    );

    // In-step counter and step index. A zero step length behaves like one, and a
    // wrap of the 16-bit counter also ends the step.
    always_comb
    begin
        count_inc  = count_reg + 16'd1;
        count_next = count_inc;
        step_next  = step_reg;
        if ((count_inc >= step_length_reg) || (count_inc == 16'd0))
        begin
            count_next = '0;
            step_next  = (step_reg == LAST_STEP) ? '0 : step_reg + AW'(1);
        end
    end

    // Glide above full scale saturates, which holds the previous value.
    assign glide_sat  = (glide_reg > nssg_pkg::GLIDE_FULL) ? nssg_pkg::GLIDE_FULL : glide_reg;
    assign glide_rest = nssg_pkg::GLIDE_FULL - glide_sat;
    assign mix_full   = 36'(prev_reg) * 36'(glide_sat) + 36'(s2_target_reg) * 36'(glide_rest);
    assign prev_next  = mix_full[12 +: nssg_pkg::SAMPLE_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_length_reg  <= nssg_pkg::STEP_LENGTH_RESET;
            gate_length_reg  <= nssg_pkg::GATE_LENGTH_RESET;
            glide_reg        <= nssg_pkg::GLIDE_RESET;
            step_reg         <= '0;
            count_reg        <= '0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            prev_reg         <= nssg_pkg::PREV_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    nssg_pkg::CFG_STEP_LENGTH: step_length_reg <= cfg_data;
                    nssg_pkg::CFG_GATE_LENGTH: gate_length_reg <= cfg_data;
                    nssg_pkg::CFG_GLIDE:       glide_reg <= nssg_pkg::GLIDE_W'(cfg_data);
                    default:                   ;
                endcase
            end

            if (clear_active_reg)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
                if (clear_addr_reg == LAST_STEP)
                begin
                    clear_active_reg <= 1'b0;
                end
            end

            if (tick_accept)
            begin
                step_reg  <= step_next;
                count_reg <= count_next;
            end

            if (advance)
            begin
                s1_valid_reg  <= tick_accept;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
                if (s2_valid_reg)
                begin
                    prev_reg <= prev_next;
                end
            end
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_gate_off_reg <= count_reg > gate_length_reg;
            s1_step_reg     <= step_reg;
        end
        if (advance)
        begin
            s2_gate_off_reg <= s1_gate_off_reg;
            s2_step_reg     <= s1_step_reg;
            s2_target_reg   <= nssg_pkg::note_pitch(ram_rdata);
            out_data_reg.sample_value <= s2_gate_off_reg ? '0 : prev_next;
            out_data_reg.current_step <= 8'(s2_step_reg);
        end
    end

    `NSSG_ASSERT_ALWAYS(a_no_accept_during_clear, !(clear_active_reg && in_ready))
    `NSSG_ASSERT_ALWAYS(a_step_in_range, 32'(step_reg) < 32'(STEPS))
    `NSSG_ASSERT_NEXT(a_gated_is_silent, advance && s2_valid_reg && s2_gate_off_reg,
        out_valid && (out_data.sample_value == '0))
    `NSSG_ASSERT_NEXT(a_prev_moves_with_tick, !(advance && s2_valid_reg), $stable(prev_reg))

endmodule

>>> tb/sv/nssg_sample_checker.sv
`timescale 1ns / 1ps

// Watches all three channels of the sequencer, keeps its own copy of the
// pattern, counters and glide state, and compares every result beat with
// the sample predicted for the oldest outstanding tick.
module nssg_sample_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  nssg_pkg::in_t                       in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  nssg_pkg::out_t                      out_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [nssg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [nssg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  errors,
    output int                                  pending,
    output int                                  checked
);

    // Pitch words of the octave starting at note 60, semitone 0 rightmost.
    localparam logic [11:0][16:0] PITCH_TABLE = {
        17'd98776, 17'd93233, 17'd88000, 17'd83061, 17'd78399, 17'd73999,
        17'd69845, 17'd65925, 17'd62225, 17'd58733, 17'd55436, 17'd52325
    };

    logic [nssg_pkg::NOTE_W-1:0]   pattern_notes [256];
    logic [7:0]                    step_pos;
    logic [15:0]                   count_in_step;
    logic [nssg_pkg::SAMPLE_W-1:0] held_value;
    logic [15:0]                   step_len;
    logic [15:0]                   gate_len;
    logic [nssg_pkg::GLIDE_W-1:0]  glide_wt;
    nssg_pkg::out_t                pending_samples [$];
    nssg_pkg::out_t                want;

    function automatic logic [nssg_pkg::SAMPLE_W-1:0] pitch_of(
        input logic [nssg_pkg::NOTE_W-1:0] note);
        int unsigned                   octave;
        logic [nssg_pkg::SAMPLE_W-1:0] base;
        octave = int'(note) / 12;
        base   = nssg_pkg::SAMPLE_W'(PITCH_TABLE[int'(note) % 12]);
        if (note == '0)
            return '0;
        if (octave < 5)
            return base >> (5 - octave);
        return base << (octave - 5);
    endfunction

    // One sample tick: glide toward the current step's pitch, gate, then
    // advance the in-step counter and, at the step boundary, the step.
    function automatic nssg_pkg::out_t glide_sample();
        logic [63:0]    weight;
        logic [63:0]    mix;
        logic [7:0]     used;
        nssg_pkg::out_t res;
        used   = step_pos;
        weight = (glide_wt > nssg_pkg::GLIDE_FULL) ? 64'd4096 : 64'(glide_wt);
        mix    = (64'(held_value) * weight
                  + 64'(pitch_of(pattern_notes[used])) * (64'd4096 - weight)) >> 12;
        held_value       = mix[nssg_pkg::SAMPLE_W-1:0];
        res.sample_value = (count_in_step > gate_len) ? '0 : held_value;
        res.current_step = used;
        count_in_step    = count_in_step + 16'd1;
        if (count_in_step >= step_len || count_in_step == 16'd0)
        begin
            count_in_step = '0;
            step_pos      = used + 8'd1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 256; i++)
                pattern_notes[i] = '0;
            step_pos      = '0;
            count_in_step = '0;
            held_value    = nssg_pkg::PREV_RESET;
            step_len      = nssg_pkg::STEP_LENGTH_RESET;
            gate_len      = nssg_pkg::GATE_LENGTH_RESET;
            glide_wt      = nssg_pkg::GLIDE_RESET;
            pending_samples.delete();
            errors        = 0;
            pending       = 0;
            checked       = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (pending_samples.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result beat, expected none, got %0d step %0d",
                             $time, out_data.sample_value, out_data.current_step);
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (out_data.sample_value !== want.sample_value)
                    begin
                        errors++;
                        $display("%0t: sample_value expected %0d, got %0d",
                                 $time, want.sample_value, out_data.sample_value);
                    end
                    if (out_data.current_step !== want.current_step)
                    begin
                        errors++;
                        $display("%0t: current_step expected %0d, got %0d",
                                 $time, want.current_step, out_data.current_step);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nssg_pkg::CFG_STEP_LENGTH: step_len = cfg_data;
                    nssg_pkg::CFG_GATE_LENGTH: gate_len = cfg_data;
                    nssg_pkg::CFG_GLIDE:       glide_wt = cfg_data[nssg_pkg::GLIDE_W-1:0];
                    default:                   ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (in_data.op == nssg_pkg::OP_WRITE)
                    pattern_notes[in_data.entry_index] = in_data.entry_note;
                else
                    pending_samples.push_back(glide_sample());
            end
            pending = pending_samples.size();
        end
    end

endmodule

>>> tb/sv/tb_note_step_sequencer_glide_core.sv
`timescale 1ns / 1ps

// Top level of the sequencer testbench. This module only produces stimulus
// and gives the verdict; all prediction and comparison happens in the
// checker instantiated beside the block.
module tb_note_step_sequencer_glide_core;

    // Cycles without any accepted beat before the run is declared hung. The
    // longest legal quiet stretch is the pattern sweep after reset or the
    // deliberate receiver hold-off, so this is generous.
    localparam int QUIET_LIMIT = 4000;
    // Length of the long receiver hold-off, in cycles.
    localparam int HOLD_CYCLES = 60;
    // Random beats per phase, and number of phases.
    localparam int PHASE_BEATS = 160;
    localparam int PHASES      = 8;
    // A register index that the block does not implement.
    localparam logic [nssg_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    nssg_pkg::in_t                    in_data = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    nssg_pkg::out_t                   out_data;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [nssg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [nssg_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    int errors;
    int pending;
    int checked;

    // Percent of cycles in which the sender idles or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    logic hold_req = 1'b0;

    int ticks_sent   = 0;
    int writes_sent  = 0;
    int reg_writes   = 0;
    int quiet_cycles = 0;

    note_step_sequencer_glide_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nssg_sample_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver stalls at random according to stall_pct. When the
    // stimulus raises hold_req, it keeps out_ready low for a long stretch so
    // the pipeline fills and the block has to drop in_ready.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog: any accepted beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Run hung: %0d cycles without an accepted beat", quiet_cycles);
                $display("note_step_sequencer_glide_core: mismatch");
                $finish;
            end
        end
    end

    // Offer one input beat, with random idle cycles ahead of it, and wait
    // until it is accepted. Valid is left high afterwards so that the next
    // beat can follow back to back; settle() lowers it.
    task automatic send_beat(input logic op, input logic [7:0] idx,
                             input logic [nssg_pkg::NOTE_W-1:0] note);
        nssg_pkg::in_t beat;
        beat.op          = op;
        beat.entry_index = idx;
        beat.entry_note  = note;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == nssg_pkg::OP_TICK)
            ticks_sent++;
        else
            writes_sent++;
    endtask

    // Ticks carry don't-care index and note fields; randomize them anyway.
    task automatic send_ticks(input int count);
        repeat (count)
            send_beat(nssg_pkg::OP_TICK, 8'($urandom), nssg_pkg::NOTE_W'($urandom));
    endtask

    // One register write. Valid stays high for a following write unless this
    // is the last one of a burst, so it is never lowered and raised in the
    // same time step.
    task automatic write_reg(input logic [nssg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [nssg_pkg::CFG_DATA_W-1:0] data, input logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (last)
            cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_setting(input logic [15:0] step_len, input logic [15:0] gate_len,
                                 input logic [15:0] glide_val);
        write_reg(nssg_pkg::CFG_STEP_LENGTH, step_len, 1'b0);
        write_reg(nssg_pkg::CFG_GATE_LENGTH, gate_len, 1'b0);
        write_reg(nssg_pkg::CFG_GLIDE, glide_val, 1'b1);
    endtask

    // Stop offering beats and wait for every predicted sample to come back.
    // The count is read at the falling edge, clear of the checker's update
    // at the rising edge. Pattern writes leave nothing to wait for, so the task
    // then waits out the three-stage pipeline before registers may change.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] rand_step;
        logic [15:0] rand_gate;
        logic [15:0] rand_glide;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // ---------------- Directed part ----------------
        // A nonzero glide before the first tick shows the reset value of the
        // previous sample blending into the silent (all zero) pattern. This
        // write lands during the post-reset pattern sweep.
        write_reg(nssg_pkg::CFG_GLIDE, 16'd2048, 1'b1);
        send_ticks(1);
        settle();

        // Step length zero must act like one, so every tick moves a step.
        // Gate at its maximum never silences anything.
        apply_setting(16'd0, 16'hFFFF, 16'd0);
        // Notes at the octave boundaries, the lowest and highest note, and the
        // highest pattern index.
        send_beat(nssg_pkg::OP_WRITE, 8'd0, 7'd1);
        send_beat(nssg_pkg::OP_WRITE, 8'd1, 7'd11);
        send_beat(nssg_pkg::OP_WRITE, 8'd2, 7'd12);
        send_beat(nssg_pkg::OP_WRITE, 8'd3, 7'd59);
        send_beat(nssg_pkg::OP_WRITE, 8'd4, 7'd60);
        send_beat(nssg_pkg::OP_WRITE, 8'd5, 7'd71);
        send_beat(nssg_pkg::OP_WRITE, 8'd6, 7'd127);
        send_beat(nssg_pkg::OP_WRITE, 8'd7, 7'd42);
        send_beat(nssg_pkg::OP_WRITE, 8'd255, 7'd85);
        send_ticks(8);
        settle();

        // Full glide weight freezes the output at the previous value.
        write_reg(nssg_pkg::CFG_GLIDE, 16'(nssg_pkg::GLIDE_FULL), 1'b1);
        send_ticks(2);
        settle();

        // A glide register above 4096 saturates and holds as well.
        write_reg(nssg_pkg::CFG_GLIDE, 16'hFFFF, 1'b1);
        send_ticks(2);
        settle();

        // An unused register index must be ignored. Then a gate of zero lets
        // only the first sample of each step through.
        write_reg(CFG_UNUSED, 16'hAAAA, 1'b0);
        apply_setting(16'd3, 16'd0, 16'd1000);
        send_ticks(3);
        settle();

        // ---------------- Random phases ----------------
        // Each phase picks a register setting and an idling pattern. Phase 1
        // uses a huge step length so the in-step count climbs, and phase 2
        // then drops the step length below that count, which must end the
        // step on the very next tick.
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct  = 0;
            stall_pct = 0;
            rand_step  = 16'($urandom_range(1, 24));
            rand_gate  = 16'($urandom_range(0, 28));
            rand_glide = 16'($urandom_range(0, 4096));
            case (p)
                0: apply_setting(16'd4, 16'd2, 16'd0);
                1: apply_setting(16'hFFFF, 16'hFFFF, 16'(nssg_pkg::GLIDE_FULL));
                2: apply_setting(16'd3, 16'd0, 16'hFFFF);
                3: apply_setting(16'd1, 16'hFFFF, 16'd2048);
                default: apply_setting(rand_step, rand_gate, rand_glide);
            endcase

            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase

            // In the first phase the receiver holds off for a long stretch
            // while beats keep coming, so the block backs up to its input.
            if (p == 0)
                hold_req = 1'b1;

            // Mostly ticks, with pattern writes mixed in so the notes that
            // ticks read keep changing under them.
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if ($urandom_range(99) < 70)
                    send_ticks(1);
                else
                    send_beat(nssg_pkg::OP_WRITE, 8'($urandom), nssg_pkg::NOTE_W'($urandom));
            end
            settle();
        end

        // Let the last results drain with neither side idling.
        idle_pct  = 0;
        stall_pct = 0;
        settle();

        $display("Sent %0d ticks and %0d pattern writes with %0d register writes;",
                 ticks_sent, writes_sent, reg_writes);
        $display("compared %0d result beats across glide, gate and step-length extremes.",
                 checked);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (errors == 0 && pending == 0)
            $display("note_step_sequencer_glide_core: match");
        else
            $display("note_step_sequencer_glide_core: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/nssg_pkg.sv
rtl/nssg_ram.sv
rtl/note_step_sequencer_glide_core.sv
tb/sv/nssg_sample_checker.sv
tb/sv/tb_note_step_sequencer_glide_core.sv
